@@ design/cb32_pkg.sv @@
// cb32_pkg: shared types, codes and alphabet functions for the base32 codec
// no dependencies; imported by cb32_step, crockford_base32_codec and cb32_checker
package cb32_pkg;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } cb32_mode_e;

  localparam int unsigned MaxBeats = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cb32_in_t;

  typedef struct packed {
    logic [7:0] value;
    logic       error;
    logic       run_last;
  } cb32_out_t;

  // all beats caused by one input item
  typedef struct packed {
    logic [1:0]                num;
    logic [MaxBeats-1:0][7:0]  val;
    logic                      err;
  } cb32_bundle_t;

  typedef struct packed {
    logic [11:0] bits;
    logic [3:0]  cnt;
    logic        skip;
  } cb32_state_t;

  localparam logic [7:0] SymTable [32] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
    8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4D, 8'h4E, 8'h50, 8'h51,
    8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
  };

  function automatic logic [7:0] sym_char(input logic [4:0] sym);
    return SymTable[sym];
  endfunction

  // {valid, index}
  function automatic logic [5:0] sym_index(input logic [7:0] ch);
    logic [7:0] idx;
    logic       ok;
    idx = 8'd0;
    ok  = 1'b1;
    case (ch) inside
      [8'h30:8'h39]: idx = ch - 8'h30;
      [8'h41:8'h48]: idx = ch - 8'h41 + 8'd10;
      [8'h4A:8'h4B]: idx = ch - 8'h4A + 8'd18;
      [8'h4D:8'h4E]: idx = ch - 8'h4D + 8'd20;
      [8'h50:8'h54]: idx = ch - 8'h50 + 8'd22;
      [8'h56:8'h5A]: idx = ch - 8'h56 + 8'd27;
      default:       ok = 1'b0;
    endcase
    return {ok, idx[4:0]};
  endfunction

endpackage

@@ design/cb32_step.sv @@
// cb32_step: combinational regrouping of one item against the pending bits
// depends on cb32_pkg (types, alphabet functions)
module cb32_step import cb32_pkg::*; (
  input  cb32_mode_e   mode_i,
  input  cb32_state_t  state_i,
  input  cb32_in_t     item_i,
  output cb32_bundle_t bundle_o,
  output cb32_state_t  state_o
);

  logic [11:0] enc_acc;
  logic [3:0]  enc_cnt;
  logic        enc_two;
  logic [3:0]  enc_sh0;
  logic [3:0]  enc_sh1;
  logic [3:0]  enc_rem;
  logic [4:0]  enc_s0;
  logic [4:0]  enc_s1;
  logic [4:0]  enc_pad;
  logic        enc_do_pad;

  logic [5:0]  dec_lut;
  logic [11:0] dec_acc;
  logic [3:0]  dec_cnt;
  logic        dec_emit;
  logic [3:0]  dec_sh;
  logic [3:0]  dec_rem;

  logic [3:0]  rem;
  logic [11:0] acc;
  logic [11:0] rem_mask;

  always_comb begin
    enc_acc    = {state_i.bits[3:0], item_i.data};
    enc_cnt    = state_i.cnt + 4'd8;
    enc_two    = enc_cnt >= 4'd10;
    enc_sh0    = enc_cnt - 4'd5;
    enc_sh1    = enc_cnt - 4'd10;
    enc_s0     = 5'(enc_acc >> enc_sh0);
    enc_s1     = 5'(enc_acc >> enc_sh1);
    enc_rem    = enc_two ? enc_sh1 : enc_sh0;
    enc_pad    = 5'(enc_acc << (3'd5 - enc_rem[2:0]));
    enc_do_pad = item_i.last && (enc_rem != 4'd0);

    dec_lut  = sym_index(item_i.data);
    dec_acc  = {state_i.bits[6:0], dec_lut[4:0]};
    dec_cnt  = state_i.cnt + 4'd5;
    dec_emit = dec_cnt >= 4'd8;
    dec_sh   = dec_cnt - 4'd8;
    dec_rem  = dec_emit ? dec_sh : dec_cnt;
  end

  always_comb begin
    bundle_o = '0;
    state_o  = state_i;
    rem      = 4'd0;
    acc      = 12'd0;
    rem_mask = 12'd0;

    if (state_i.skip) begin
      state_o.skip = !item_i.last;
    end else begin
      case (mode_i)
        MODE_ENCODE: begin
          acc             = enc_acc;
          rem             = enc_rem;
          bundle_o.val[0] = sym_char(enc_s0);
          if (enc_two) begin
            bundle_o.val[1] = sym_char(enc_s1);
            bundle_o.val[2] = sym_char(enc_pad);
            bundle_o.num    = enc_do_pad ? 2'd3 : 2'd2;
          end else begin
            bundle_o.val[1] = sym_char(enc_pad);
            bundle_o.num    = enc_do_pad ? 2'd2 : 2'd1;
          end
        end
        MODE_DECODE: begin
          acc             = dec_acc;
          rem             = dec_rem;
          bundle_o.val[0] = 8'(dec_acc >> dec_sh);
          bundle_o.num    = dec_emit ? 2'd1 : 2'd0;
          if (!dec_lut[5]) begin
            bundle_o.val[0] = 8'd0;
            bundle_o.err    = 1'b1;
            bundle_o.num    = 2'd1;
            rem             = 4'd0;
            state_o.skip    = !item_i.last;
          end
        end
        default: begin
          bundle_o.num = 2'd0;
        end
      endcase

      rem_mask     = (12'd1 << rem) - 12'd1;
      state_o.bits = acc & rem_mask;
      state_o.cnt  = rem;
      if (item_i.last) begin
        state_o.bits = 12'd0;
        state_o.cnt  = 4'd0;
      end
    end
  end

endmodule

@@ design/crockford_base32_codec.sv @@
// crockford_base32_codec: streaming codec between bytes and base32 characters
// depends on cb32_pkg and cb32_step
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o   cb32_in_t  {data, last}
//  out       output     out_valid_o / out_stall_i cb32_out_t {value, error, run_last}
//  cfg       input      cfg_we_i                  cfg_wdata_i (mode)
//
// an item waits in the input register, then its n beats (0 to 3) leave at one
// beat per cycle, unless the output stalls, from a two-entry result queue; the
// output port sets the pace: a byte gives 1 to 3 characters, a character 0 or 1 byte
// reset clears mode, pending bits and skip flag, and empties the input register and the result queue
// a stalled output holds its beat; the input stalls only when the queue is full
module crockford_base32_codec import cb32_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cb32_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output cb32_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  cb32_mode_e   mode_q;
  cb32_state_t  state_q;
  cb32_state_t  state_d;
  logic         in_vld_q;
  cb32_in_t     in_q;
  cb32_bundle_t bundle;
  cb32_bundle_t queue_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   cnt_q;
  logic [1:0]   sub_q;
  cb32_bundle_t head;
  logic         in_accept;
  logic         out_accept;
  logic         pop;
  logic         push;
  logic         adv;

  cb32_step u_step (
    .mode_i   (mode_q),
    .state_i  (state_q),
    .item_i   (in_q),
    .bundle_o (bundle),
    .state_o  (state_d)
  );

  always_comb begin
    head        = queue_q[rd_ptr_q];
    out_valid_o = cnt_q != 2'd0;
    out_data_o.error    = head.err;
    out_data_o.run_last = (sub_q + 2'd1) == head.num;
    case (sub_q)
      2'd0:    out_data_o.value = head.val[0];
      2'd1:    out_data_o.value = head.val[1];
      2'd2:    out_data_o.value = head.val[2];
      default: out_data_o.value = head.val[0];
    endcase
    out_accept = out_valid_o && !out_stall_i;
    pop        = out_accept && out_data_o.run_last;
    adv        = (bundle.num == 2'd0) || (cnt_q != 2'd2) || pop;
    push       = in_vld_q && adv && (bundle.num != 2'd0);
    in_stall_o = in_vld_q && !adv;
    in_accept  = in_valid_i && !in_stall_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ENCODE;
      state_q  <= '0;
      in_vld_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      sub_q    <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        mode_q  <= cb32_mode_e'(cfg_wdata_i);
        state_q <= '0;
      end else if (in_vld_q && adv) begin
        state_q <= state_d;
      end
      in_vld_q <= in_accept || (in_vld_q && !adv);
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (out_accept) begin
        sub_q <= out_data_o.run_last ? 2'd0 : sub_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (push) begin
      queue_q[wr_ptr_q] <= bundle;
    end
  end

endmodule

@@ design/cb32_checker.sv @@
// cb32_checker: port-level assertions for crockford_base32_codec, bound to the top
// depends on cb32_pkg and crockford_base32_codec
module cb32_checker import cb32_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input cb32_out_t out_data_o,
  input logic      cfg_we_i
);

  // a stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // an error beat is alone and carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.run_last && out_data_o.value == 8'd0)
    else $error("malformed error beat");

  // with nothing queued the input never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output queue");

  // a beat that is not the last of its item is followed by another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.run_last |=> out_valid_o)
    else $error("item beats interrupted");

  // the user must keep mode writes to an idle codec; the codec does not enforce it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !out_valid_o && !in_valid_i)
    else $error("mode write with beats in flight");

endmodule

bind crockford_base32_codec cb32_checker u_cb32_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i)
);
